@@ rtl/stp_pkg.sv @@
// Shared types and constants for the step/direction pulse generator.
// Holds the command codes, field widths and the item and result structs.
// No dependencies; every other file in rtl imports this package.
package stp_pkg;

    localparam int POS_W     = 32;
    localparam int PERIOD_W  = 24;
    localparam int CMD_W     = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = {PERIOD_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_SET_TARGET = 3'd1,
        CMD_SET_DIR    = 3'd2,
        CMD_ABORT      = 3'd3,
        CMD_FORCE_LOW  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] target_position;
        logic             clockwise;
    } item_t;

    typedef struct packed {
        logic             step_pin;
        logic             dir_pin;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] steps_left;
        logic             busy_res;
    } result_t;

endpackage

@@ rtl/stp_in_stage.sv @@
// Input register for the pulse generator: captures one transaction from the
// slave stream and holds it until the core consumes it.
// Depends on stp_pkg for the item struct.
module stp_in_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [stp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [stp_pkg::CMD_W-1:0]    s_tuser,
    input  logic                         advance,
    output stp_pkg::item_t               item,
    output logic                         item_valid
);
    import stp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd             <= s_tuser;
            item_reg.target_position <= s_tdata[POS_W-1:0];
            item_reg.clockwise       <= s_tdata[POS_W];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

@@ rtl/stp_core.sv @@
// Motion state of the pulse generator: position, remaining steps, elapsed
// time, pulse phase, step level and direction, plus the period register.
// Depends on stp_pkg; applies one item per cycle when exec is high.
module stp_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [stp_pkg::PERIOD_W-1:0] cfg_wr_data,
    input  logic                        exec,
    input  stp_pkg::item_t              item,
    output stp_pkg::result_t            result
);
    import stp_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [POS_W-1:0]    rem_reg,     rem_next;
    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next;
    logic                phase_reg,   phase_next;
    logic                step_reg,    step_next;
    logic                cw_reg,      cw_next;

    logic [PERIOD_W-1:0] elapsed_inc;
    logic [PERIOD_W-1:0] half_period;
    logic [POS_W:0]      diff_fwd;
    logic [POS_W:0]      diff_rev;
    logic                dist_positive;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;
    assign half_period = period_reg >> 1;

    assign diff_fwd = {item.target_position[POS_W-1], item.target_position}
                    - {pos_reg[POS_W-1], pos_reg};
    assign diff_rev = {pos_reg[POS_W-1], pos_reg}
                    - {item.target_position[POS_W-1], item.target_position};
    assign dist_positive = !diff_fwd[POS_W] && (diff_fwd != '0);

    always_comb
    begin
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        step_next    = step_reg;
        cw_next      = cw_reg;
        if (exec)
        begin
            unique case (item.cmd)
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if ((rem_reg != '0) && (elapsed_inc >= half_period))
                    begin
                        elapsed_next = '0;
                        phase_next   = !phase_reg;
                        if (phase_reg)
                        begin
                            step_next = 1'b0;
                            rem_next  = rem_reg - 1'b1;
                            pos_next  = cw_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                        end
                        else
                        begin
                            step_next = 1'b1;
                        end
                    end
                end
                CMD_SET_TARGET:
                begin
                    cw_next  = dist_positive;
                    rem_next = dist_positive ? diff_fwd[POS_W-1:0]
                                             : diff_rev[POS_W-1:0];
                end
                CMD_SET_DIR:
                begin
                    cw_next = item.clockwise;
                end
                CMD_ABORT:
                begin
                    rem_next = '0;
                end
                CMD_FORCE_LOW:
                begin
                    step_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= '0;
            pos_reg     <= '0;
            rem_reg     <= '0;
            elapsed_reg <= '0;
            phase_reg   <= 1'b0;
            step_reg    <= 1'b0;
            cw_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            pos_reg     <= pos_next;
            rem_reg     <= rem_next;
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            cw_reg      <= cw_next;
        end
    end

    assign result.step_pin   = step_reg;
    assign result.dir_pin    = !cw_reg;
    assign result.position   = pos_reg;
    assign result.steps_left = rem_reg;
    assign result.busy_res   = (rem_reg != '0);

    // The position moves only when the pulse phase falls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> $fell(phase_reg))
        else $error("position moved without a falling pulse phase");

    // Without a new target the remaining step count never grows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (item.cmd != CMD_SET_TARGET)) |=> (rem_reg <= $past(rem_reg)))
        else $error("remaining steps grew without a set_target");

    // Nothing but an executed item changes the motion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> ($stable(pos_reg) && $stable(rem_reg) && $stable(elapsed_reg)))
        else $error("motion state changed while no item was executed");

endmodule

@@ rtl/stepper_step_dir_pulse_generator_unit.sv @@
// Top level of the step/direction pulse generator.
// Instantiates stp_in_stage and stp_core; depends on stp_pkg.
//
// Usage:
//   The slave stream carries one command per transaction: s_tuser holds the
//   command code and s_tdata the target position and the direction flag.
//   A tick command stands for one microsecond of time. Every transaction
//   produces exactly one result on the master stream, showing the step and
//   direction levels, the position and the remaining steps after it.
//   The period register is written through cfg_wr_en and cfg_wr_data while
//   no transaction is in flight.
// Pipeline:
//   An accepted transaction is held in the input register and then executed
//   into the motion state registers. One transaction is accepted every cycle
//   while the master side does not stall. The motion state registers double
//   as the result register; the input register lets a new transaction be
//   taken while a result waits on the master side.
// Reset:
//   rst_n clears the position, the step count, the timer, the period and
//   the step level, and sets the direction to clockwise.
// Stall:
//   While a result waits and m_tready is low the result holds, the state does
//   not advance, and s_tready drops once the input register is full.
module stepper_step_dir_pulse_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [stp_pkg::PERIOD_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0: target_position[31:0], clockwise[32], zero pad.
    input  logic [stp_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: cmd[2:0].
    input  logic [stp_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0: step_pin[0], dir_pin[1], position[33:2],
    // steps_left[65:34], busy_res[66], zero pad.
    output logic [stp_pkg::M_TDATA_W-1:0] m_tdata
);
    import stp_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    logic    m_valid_reg;
    logic    m_valid_next;

    assign advance = item_valid && (!m_valid_reg || m_tready);

    stp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    stp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .exec        (advance),
        .item        (item),
        .result      (result)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (advance)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*POS_W - 3){1'b0}},
                       result.busy_res,
                       result.steps_left,
                       result.position,
                       result.dir_pin,
                       result.step_pin};

    // A full input register behind a stalled result must block the slave.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are stalled");

    // Every executed item leaves a result pending on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_valid_reg)
        else $error("executed transaction produced no result");

    // A pending result that is not taken blocks execution of the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !advance)
        else $error("item executed over a result still waiting");

endmodule

@@ tb/tb.sv @@
// Testbench for the step/direction pulse generator top level.
// Streams commands and ticks, predicts every result in place and checks them.
// Depends on stp_pkg and stepper_step_dir_pulse_generator_unit.
`timescale 1ns / 1ps

module tb;

    import stp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int NUM_PHASES  = 10;
    localparam int HOLD_PHASE  = 5;
    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0]   cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    stepper_step_dir_pulse_generator_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 clk = ~clk;

    // Motion state of the predictor.
    logic [POS_W-1:0]    motor_pos = '0;
    logic [POS_W-1:0]    motor_steps = '0;
    logic [PERIOD_W-1:0] motor_elapsed = '0;
    logic                motor_phase_hi = 1'b0;
    logic                motor_step_lv = 1'b0;
    logic                motor_cw = 1'b1;
    logic [PERIOD_W-1:0] motor_period = '0;

    item_t   cmd_queue[$];
    result_t motion_expected[$];
    item_t   cur_item;
    bit      in_fire = 1'b0;
    int      send_idle_pct = 0;
    int      rcv_idle_pct = 0;
    int      phase_idx = -1;
    int      hold_left = 0;
    bit      hold_done = 1'b0;
    int      err_cnt = 0;
    int      accepted_cnt = 0;
    int      checked_cnt = 0;
    int      step_cnt = 0;

    function automatic item_t make_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] tgt, logic cw);
        item_t it;
        it.cmd = c;
        it.target_position = tgt;
        it.clockwise = cw;
        return it;
    endfunction

    function automatic result_t advance_motor(item_t it);
        result_t r;
        logic signed [POS_W:0] distance;
        logic signed [POS_W:0] mag;
        case (it.cmd)
            CMD_TICK:
            begin
                if (motor_elapsed != ELAPSED_MAX)
                    motor_elapsed = motor_elapsed + 1'b1;
                if (motor_steps != 0 && motor_elapsed >= (motor_period >> 1))
                begin
                    motor_elapsed = '0;
                    if (motor_phase_hi)
                    begin
                        motor_step_lv = 1'b0;
                        motor_steps = motor_steps - 1'b1;
                        motor_pos = motor_cw ? motor_pos + 1'b1 : motor_pos - 1'b1;
                        step_cnt++;
                    end
                    else
                        motor_step_lv = 1'b1;
                    motor_phase_hi = ~motor_phase_hi;
                end
            end
            CMD_SET_TARGET:
            begin
                distance = $signed({it.target_position[POS_W-1], it.target_position})
                         - $signed({motor_pos[POS_W-1], motor_pos});
                if (distance > 0)
                begin
                    motor_cw = 1'b1;
                    motor_steps = distance[POS_W-1:0];
                end
                else
                begin
                    mag = -distance;
                    motor_cw = 1'b0;
                    motor_steps = mag[POS_W-1:0];
                end
            end
            CMD_SET_DIR:   motor_cw = it.clockwise;
            CMD_ABORT:     motor_steps = '0;
            CMD_FORCE_LOW: motor_step_lv = 1'b0;
            default:       ;
        endcase
        r.step_pin = motor_step_lv;
        r.dir_pin = ~motor_cw;
        r.position = motor_pos;
        r.steps_left = motor_steps;
        r.busy_res = (motor_steps != 0);
        return r;
    endfunction

    // Driver: holds an offered transaction until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_item = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_item.cmd;
                s_tdata <= {{(S_TDATA_W-POS_W-1){1'b0}}, cur_item.clockwise,
                            cur_item.target_position};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver readiness, with one long hold-off while the sender keeps going.
    always @(negedge clk)
    begin
        if (phase_idx == HOLD_PHASE && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Monitor: predicts on each accepted input and checks each accepted result.
    always @(posedge clk)
    begin
        result_t want;
        in_fire = 1'b0;
        if (rst_n && s_tvalid && s_tready)
        begin
            in_fire = 1'b1;
            accepted_cnt++;
            motion_expected.push_back(advance_motor(cur_item));
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (motion_expected.size() == 0)
            begin
                $error("Result transaction with no expectation: m_tdata=%h", m_tdata);
                err_cnt++;
            end
            else
            begin
                want = motion_expected.pop_front();
                checked_cnt++;
                if (m_tdata[0] !== want.step_pin)
                begin
                    $error("step_pin: expected %0d, got %0d", want.step_pin, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tdata[1] !== want.dir_pin)
                begin
                    $error("dir_pin: expected %0d, got %0d", want.dir_pin, m_tdata[1]);
                    err_cnt++;
                end
                if (m_tdata[33:2] !== want.position)
                begin
                    $error("position: expected %0d, got %0d",
                           $signed(want.position), $signed(m_tdata[33:2]));
                    err_cnt++;
                end
                if (m_tdata[65:34] !== want.steps_left)
                begin
                    $error("steps_left: expected %0d, got %0d", want.steps_left,
                           m_tdata[65:34]);
                    err_cnt++;
                end
                if (m_tdata[66] !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, m_tdata[66]);
                    err_cnt++;
                end
            end
        end
    end

    task automatic write_period(logic [PERIOD_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        motor_period = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_block();
        while (cmd_queue.size() > 0 || s_tvalid || motion_expected.size() > 0 || hold_left > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly moves toward nearby targets followed by ticks, with other commands mixed in.
    task automatic queue_random_work(int count, logic [POS_W-1:0] base);
        int n;
        int ticks;
        int pick;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                cmd_queue.push_back(make_cmd(CMD_SET_TARGET,
                                    POS_W'(base + $urandom_range(0, 60) - 30),
                                    1'($urandom_range(0, 1))));
                ticks = $urandom_range(4, 40);
                repeat (ticks)
                    cmd_queue.push_back(make_cmd(CMD_TICK, $urandom,
                                                 1'($urandom_range(0, 1))));
                n += ticks + 1;
            end
            else
            begin
                if (pick < 70)
                    cmd_queue.push_back(make_cmd(CMD_TICK, $urandom,
                                                 1'($urandom_range(0, 1))));
                else if (pick < 76)
                    cmd_queue.push_back(make_cmd(CMD_SET_DIR, $urandom,
                                                 1'($urandom_range(0, 1))));
                else if (pick < 82)
                    cmd_queue.push_back(make_cmd(CMD_ABORT, $urandom,
                                                 1'($urandom_range(0, 1))));
                else if (pick < 89)
                    cmd_queue.push_back(make_cmd(CMD_FORCE_LOW, $urandom,
                                                 1'($urandom_range(0, 1))));
                else if (pick < 95)
                    cmd_queue.push_back(make_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST,
                                                 CMD_SPARE_LAST)), $urandom,
                                                 1'($urandom_range(0, 1))));
                else
                    cmd_queue.push_back(make_cmd(CMD_SET_TARGET, $urandom,
                                                 1'($urandom_range(0, 1))));
                n++;
            end
        end
    endtask

    initial
    begin
        logic [PERIOD_W-1:0] periods [NUM_PHASES];
        periods = '{24'd0, 24'd1, 24'd3, 24'hFFFFFF, 24'd4, 24'd5, 24'h800001,
                    24'd7, 24'd6, 24'd2};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_period(24'd3);
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SET_TARGET, 32'h0000_0000, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_SET_TARGET, 32'h0000_0003, 1'b0));
        repeat (5) cmd_queue.push_back(make_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_FORCE_LOW, 32'h0000_0000, 1'b0));
        repeat (3) cmd_queue.push_back(make_cmd(CMD_TICK, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SET_DIR, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SET_DIR, 32'hFFFF_FFFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_ABORT, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_SPARE_MID, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SPARE_LAST, 32'hFFFF_FFFF, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_SET_TARGET, 32'h8000_0000, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_TICK, 32'h0000_0000, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_SET_TARGET, 32'h7FFF_FFFF, 1'b0));
        cmd_queue.push_back(make_cmd(CMD_ABORT, 32'h0000_0000, 1'b1));
        cmd_queue.push_back(make_cmd(CMD_SET_TARGET, 32'hFFFF_FFFE, 1'b0));
        drain_block();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 11;
                rcv_idle_pct = 63;
            end
            else if (p < 7)
            begin
                send_idle_pct = 63;
                rcv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_period(periods[p]);
            queue_random_work(60, motor_pos);
            phase_idx = p;
            drain_block();
        end

        repeat (10) @(negedge clk);
        $display("Run covered %0d transactions and %0d checked results, %0d steps taken,",
                 accepted_cnt, checked_cnt, step_cnt);
        $display("over %0d step period settings including zero and full scale.",
                 NUM_PHASES + 1);
        if (err_cnt == 0 && motion_expected.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
